// File: sv/bpr_pkg.sv
// Package for the bus packet receiver: frame states, event codes,
// register indexes, reset values and the structs passed between modules.
// No dependencies.
package bpr_pkg;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_LEADIN = 3'd1,
    ST_DEST   = 3'd2,
    ST_SRC    = 3'd3,
    ST_CMD    = 3'd4,
    ST_LEN    = 3'd5,
    ST_DATA   = 3'd6,
    ST_SUM    = 3'd7
  } frame_state_t;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_ACCEPTED  = 3'd1;
  localparam logic [2:0] EV_NOT_ADDR  = 3'd2;
  localparam logic [2:0] EV_CHECKSUM  = 3'd3;
  localparam logic [2:0] EV_TIMEOUT   = 3'd4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEADIN_BYTE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDR   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ADDR  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PROMISC     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RX_TIMEOUT  = 3'd5;

  localparam logic [7:0]  RST_START_BYTE  = 8'd187;
  localparam logic [7:0]  RST_LEADIN_BYTE = 8'd136;
  localparam logic [7:0]  RST_NODE_ADDR   = 8'd31;
  localparam logic [7:0]  RST_GROUP_ADDR  = 8'd120;
  localparam logic [15:0] RST_RX_TIMEOUT  = 16'd50;

  localparam logic [7:0] BROADCAST_ADDR = 8'd255;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  leadin_byte;
    logic [7:0]  node_address;
    logic [7:0]  group_address;
    logic        promiscuous;
    logic [15:0] receive_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] dest_out;
    logic [7:0] source_out;
    logic [7:0] command_out;
    logic [7:0] length_out;
  } result_t;

endpackage

// File: sv/bpr_frame.sv
// Frame parser of the bus packet receiver: holds the frame state and
// computes one result per request. Depends on bpr_pkg.
module bpr_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              mode,
  input  logic [7:0]        rx_byte,
  input  bpr_pkg::cfg_t     cfg,
  output bpr_pkg::result_t  result
);

  bpr_pkg::frame_state_t frame_state, frame_state_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  data_count, data_count_next;
  logic [7:0]  data_length, data_length_next;
  logic [7:0]  dest_held, dest_held_next;
  logic [7:0]  source_held, source_held_next;
  logic [7:0]  command_held, command_held_next;
  logic        addressed, addressed_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic [16:0] ticks_inc;
  logic        timeout_hit;
  logic [7:0]  sum_add;
  logic [7:0]  count_inc;
  logic        dest_match;

  // A zero timeout compares as one: the first idle tick always hits.
  assign ticks_inc   = {1'b0, idle_ticks} + 17'd1;
  assign timeout_hit = ticks_inc >= {1'b0, cfg.receive_timeout};
  assign sum_add     = running_sum + rx_byte;
  assign count_inc   = data_count + 8'd1;
  assign dest_match  = (rx_byte == cfg.node_address) || (rx_byte == cfg.group_address) ||
                       (rx_byte == bpr_pkg::BROADCAST_ADDR) || cfg.promiscuous;

  // Next state.
  always_comb begin
    frame_state_next  = frame_state;
    running_sum_next  = running_sum;
    data_count_next   = data_count;
    data_length_next  = data_length;
    dest_held_next    = dest_held;
    source_held_next  = source_held;
    command_held_next = command_held;
    addressed_next    = addressed;
    idle_ticks_next   = idle_ticks;
    if (mode) begin
      if (frame_state != bpr_pkg::ST_START) begin
        if (timeout_hit) begin
          frame_state_next = bpr_pkg::ST_START;
          running_sum_next = 8'd0;
          data_count_next  = 8'd0;
          data_length_next = 8'd0;
          addressed_next   = 1'b0;
          idle_ticks_next  = 16'd0;
        end else begin
          idle_ticks_next = ticks_inc[15:0];
        end
      end
    end else begin
      idle_ticks_next = 16'd0;
      unique case (frame_state)
        bpr_pkg::ST_START: begin
          if (rx_byte == cfg.start_byte) frame_state_next = bpr_pkg::ST_LEADIN;
        end
        bpr_pkg::ST_LEADIN: begin
          if (rx_byte == cfg.leadin_byte) begin
            frame_state_next = bpr_pkg::ST_DEST;
            running_sum_next = 8'd0;
          end else if (rx_byte != cfg.start_byte) begin
            frame_state_next = bpr_pkg::ST_START;
            running_sum_next = 8'd0;
            data_count_next  = 8'd0;
            data_length_next = 8'd0;
            addressed_next   = 1'b0;
          end
        end
        bpr_pkg::ST_DEST: begin
          dest_held_next   = rx_byte;
          addressed_next   = dest_match;
          running_sum_next = sum_add;
          frame_state_next = bpr_pkg::ST_SRC;
        end
        bpr_pkg::ST_SRC: begin
          source_held_next = rx_byte;
          running_sum_next = sum_add;
          frame_state_next = bpr_pkg::ST_CMD;
        end
        bpr_pkg::ST_CMD: begin
          command_held_next = rx_byte;
          running_sum_next  = sum_add;
          frame_state_next  = bpr_pkg::ST_LEN;
        end
        bpr_pkg::ST_LEN: begin
          data_length_next = rx_byte;
          data_count_next  = 8'd0;
          running_sum_next = sum_add;
          frame_state_next = (rx_byte == 8'd0) ? bpr_pkg::ST_SUM : bpr_pkg::ST_DATA;
        end
        bpr_pkg::ST_DATA: begin
          running_sum_next = sum_add;
          data_count_next  = count_inc;
          if (count_inc == data_length) frame_state_next = bpr_pkg::ST_SUM;
        end
        bpr_pkg::ST_SUM: begin
          frame_state_next = bpr_pkg::ST_START;
          running_sum_next = 8'd0;
          data_count_next  = 8'd0;
          data_length_next = 8'd0;
          addressed_next   = 1'b0;
        end
        default: frame_state_next = bpr_pkg::ST_START;
      endcase
    end
  end

  // Result of the current request.
  always_comb begin
    result = '0;
    if (mode) begin
      if (frame_state != bpr_pkg::ST_START && timeout_hit) begin
        result.event_res = bpr_pkg::EV_TIMEOUT;
      end
    end else begin
      unique case (frame_state)
        bpr_pkg::ST_DATA: begin
          if (addressed) begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = data_count;
          end
        end
        bpr_pkg::ST_SUM: begin
          if (rx_byte != running_sum) begin
            result.event_res = bpr_pkg::EV_CHECKSUM;
          end else if (addressed) begin
            result.event_res   = bpr_pkg::EV_ACCEPTED;
            result.dest_out    = dest_held;
            result.source_out  = source_held;
            result.command_out = command_held;
            result.length_out  = data_length;
          end else begin
            result.event_res = bpr_pkg::EV_NOT_ADDR;
          end
        end
        default: result.event_res = bpr_pkg::EV_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state  <= bpr_pkg::ST_START;
      running_sum  <= 8'd0;
      data_count   <= 8'd0;
      data_length  <= 8'd0;
      dest_held    <= 8'd0;
      source_held  <= 8'd0;
      command_held <= 8'd0;
      addressed    <= 1'b0;
      idle_ticks   <= 16'd0;
    end else if (step) begin
      frame_state  <= frame_state_next;
      running_sum  <= running_sum_next;
      data_count   <= data_count_next;
      data_length  <= data_length_next;
      dest_held    <= dest_held_next;
      source_held  <= source_held_next;
      command_held <= command_held_next;
      addressed    <= addressed_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

`ifndef ASSERT_OFF
  // Idle ticks only count while a packet is in progress.
  a_idle_only_in_packet: assert property (@(posedge clk) disable iff (rst)
    (frame_state == bpr_pkg::ST_START) |-> (idle_ticks == 16'd0))
    else $error("idle tick count nonzero while waiting for a start byte");

  // In the payload state the count has not yet reached the length.
  a_count_below_length: assert property (@(posedge clk) disable iff (rst)
    (frame_state == bpr_pkg::ST_DATA) |-> (data_count < data_length))
    else $error("payload count reached the length without leaving the payload state");

  // A checksum byte always ends the packet.
  a_sum_ends_packet: assert property (@(posedge clk) disable iff (rst)
    (step && !mode && frame_state == bpr_pkg::ST_SUM) |=>
      (frame_state == bpr_pkg::ST_START && running_sum == 8'd0))
    else $error("packet not closed after the checksum byte");

  // A payload byte is never reported together with a final event.
  a_payload_no_event: assert property (@(posedge clk) disable iff (rst)
    result.payload_valid |-> (result.event_res == bpr_pkg::EV_NONE && addressed))
    else $error("payload byte reported with an event or for a foreign packet");
`endif

endmodule

// File: sv/bus_packet_receiver.sv
// Top level of the bus packet receiver: configuration registers, input
// register, frame parser and output register. Depends on bpr_pkg, bpr_frame.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   mode, rx_byte
//   out      output     out_valid / out_stall event_res, payload_*, *_out
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; each request is held in the
// input register, the parser computes its result, and the output register holds it.
// Reset clears the configuration to its defaults and the frame to waiting for
// a start byte. The input register takes one more request while a result
// waits in the output register; in_stall rises only when both are full.
module bus_packet_receiver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         event_res,
  output logic                               payload_valid,
  output logic [7:0]                         payload_byte,
  output logic [7:0]                         payload_index,
  output logic [7:0]                         dest_out,
  output logic [7:0]                         source_out,
  output logic [7:0]                         command_out,
  output logic [7:0]                         length_out,
  input  logic                               cfg_write,
  input  logic [bpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  bpr_pkg::cfg_t    cfg;
  bpr_pkg::result_t result;
  bpr_pkg::result_t out_reg;

  logic       hold_valid;
  logic       hold_mode;
  logic [7:0] hold_byte;
  logic       advance;
  logic       accept;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte      <= bpr_pkg::RST_START_BYTE;
      cfg.leadin_byte     <= bpr_pkg::RST_LEADIN_BYTE;
      cfg.node_address    <= bpr_pkg::RST_NODE_ADDR;
      cfg.group_address   <= bpr_pkg::RST_GROUP_ADDR;
      cfg.promiscuous     <= 1'b0;
      cfg.receive_timeout <= bpr_pkg::RST_RX_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bpr_pkg::REG_START_BYTE:  cfg.start_byte      <= cfg_data[7:0];
        bpr_pkg::REG_LEADIN_BYTE: cfg.leadin_byte     <= cfg_data[7:0];
        bpr_pkg::REG_NODE_ADDR:   cfg.node_address    <= cfg_data[7:0];
        bpr_pkg::REG_GROUP_ADDR:  cfg.group_address   <= cfg_data[7:0];
        bpr_pkg::REG_PROMISC:     cfg.promiscuous     <= cfg_data[0];
        bpr_pkg::REG_RX_TIMEOUT:  cfg.receive_timeout <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_mode <= mode;
      hold_byte <= rx_byte;
    end
  end

  bpr_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .mode    (hold_mode),
    .rx_byte (hold_byte),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign event_res     = out_reg.event_res;
  assign payload_valid = out_reg.payload_valid;
  assign payload_byte  = out_reg.payload_byte;
  assign payload_index = out_reg.payload_index;
  assign dest_out      = out_reg.dest_out;
  assign source_out    = out_reg.source_out;
  assign command_out   = out_reg.command_out;
  assign length_out    = out_reg.length_out;

endmodule
